>>> sv/bqlpf_pkg.sv
// ----------------------------------------------------------------------------
// bqlpf_pkg
// Shared types, constants and the control-store contents for the biquad
// low-pass filter sequencer.
// ----------------------------------------------------------------------------
package bqlpf_pkg;

  localparam int COEF_W    = 20;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 20'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_idx_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    CS_A1,
    CS_A2,
    CS_B0,
    CS_B1,
    CS_B2
  } coef_sel_t;

  typedef enum logic [1:0] {
    SS_D1,
    SS_D2,
    SS_W
  } st_sel_t;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NONE, // always advance
    COND_IN,   // advance on input transfer
    COND_OUT   // advance when the output register can take a result
  } cond_t;

  typedef struct packed {
    cond_t     cond;
    logic      mul_en;
    coef_sel_t coef_sel;
    st_sel_t   st_sel;
    acc_op_t   acc_op;
    logic      ld_x;
    logic      ld_w;
    logic      ld_y;
    step_t     next;
  } ucode_t;

  localparam step_t STEP_FETCH = 3'd0;
  localparam step_t STEP_FB1   = 3'd1;
  localparam step_t STEP_FB2   = 3'd2;
  localparam step_t STEP_FF1   = 3'd3;
  localparam step_t STEP_WCALC = 3'd4;
  localparam step_t STEP_FF0   = 3'd5;
  localparam step_t STEP_ACCW  = 3'd6;
  localparam step_t STEP_EMIT  = 3'd7;

  // Control store. Product register is one step behind the multiply, so the
  // accumulator folds in the product issued on the previous step.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = '{cond: COND_NONE, mul_en: 1'b0, coef_sel: CS_A1, st_sel: SS_D1,
           acc_op: ACC_NOP, ld_x: 1'b0, ld_w: 1'b0, ld_y: 1'b0,
           next: STEP_FETCH};
    case (step)
      STEP_FETCH: begin
        uc.cond = COND_IN;
        uc.ld_x = 1'b1;
        uc.next = STEP_FB1;
      end
      STEP_FB1: begin
        uc.mul_en   = 1'b1;
        uc.coef_sel = CS_A1;
        uc.st_sel   = SS_D1;
        uc.next     = STEP_FB2;
      end
      STEP_FB2: begin
        uc.mul_en   = 1'b1;
        uc.coef_sel = CS_A2;
        uc.st_sel   = SS_D2;
        uc.acc_op   = ACC_LOAD;
        uc.next     = STEP_FF1;
      end
      STEP_FF1: begin
        uc.mul_en   = 1'b1;
        uc.coef_sel = CS_B1;
        uc.st_sel   = SS_D1;
        uc.acc_op   = ACC_ADD;
        uc.next     = STEP_WCALC;
      end
      STEP_WCALC: begin
        uc.ld_w     = 1'b1;
        uc.mul_en   = 1'b1;
        uc.coef_sel = CS_B2;
        uc.st_sel   = SS_D2;
        uc.acc_op   = ACC_LOAD;
        uc.next     = STEP_FF0;
      end
      STEP_FF0: begin
        uc.mul_en   = 1'b1;
        uc.coef_sel = CS_B0;
        uc.st_sel   = SS_W;
        uc.acc_op   = ACC_ADD;
        uc.next     = STEP_ACCW;
      end
      STEP_ACCW: begin
        uc.acc_op = ACC_ADD;
        uc.next   = STEP_EMIT;
      end
      STEP_EMIT: begin
        uc.cond = COND_OUT;
        uc.ld_y = 1'b1;
        uc.next = STEP_FETCH;
      end
      default: begin
        uc.next = STEP_FETCH;
      end
    endcase
    return uc;
  endfunction

endpackage

>>> sv/biquad_lowpass_filter.sv
// A result is offered once its input has passed steps FB1, FB2, FF1, WCALC,
// FF0, ACCW and EMIT. A new sample is taken only when the 8-step control
// program driving a single shared coefficient multiplier and one accumulator ends.
// A finished result waits in the output register while the next sample runs.
// Reset (rst_n low, synchronous): delays cleared, b0 = 1.0, other coefs 0.
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Direct form II biquad section, fixed point, microcoded over one multiplier.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int STATE_WIDTH    = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         out_sample_out,
  output logic                                   out_saturated,
  input  logic                                   cfg_wr_en,
  input  logic [bqlpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bqlpf_pkg::COEF_W-1:0]           cfg_wdata
);

  localparam int CW     = bqlpf_pkg::COEF_W;
  localparam int PROD_W = CW + STATE_WIDTH;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W:0] RND_HALF =
    {{(ACC_W + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [ACC_W+1:0] W_MAX =
    {{(ACC_W + 3 - STATE_WIDTH){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W+1:0] W_MIN = ~W_MAX;
  localparam logic signed [ACC_W:0] Y_MAX =
    {{(ACC_W + 2 - SAMPLE_WIDTH){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W:0] Y_MIN = ~Y_MAX;

  // coefficients
  logic signed [CW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  // sequencer
  bqlpf_pkg::step_t  step_r, step_nxt;
  bqlpf_pkg::ucode_t uc;
  logic              adv;

  // datapath
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [STATE_WIDTH-1:0]  d1_r, d2_r, w_r, w_nxt;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [CW-1:0]           coef_op;
  logic signed [STATE_WIDTH-1:0]  st_op;
  logic signed [ACC_W:0]          acc_rnd, acc_q;
  logic signed [ACC_W+1:0]        w_full;
  logic                           w_clip, y_clip, clip_r;
  logic signed [SAMPLE_WIDTH-1:0] y_nxt;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_sat_r;

  assign uc = bqlpf_pkg::ucode_rom(step_r);

  always_comb begin
    case (uc.cond)
      bqlpf_pkg::COND_IN:  adv = in_valid;
      bqlpf_pkg::COND_OUT: adv = !out_valid_r || !out_stall;
      default:             adv = 1'b1;
    endcase
  end

  assign step_nxt = adv ? uc.next : step_r;
  assign in_stall = (uc.cond != bqlpf_pkg::COND_IN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bqlpf_pkg::STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= bqlpf_pkg::COEF_B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bqlpf_pkg::CFG_B0: b0_r <= cfg_wdata;
        bqlpf_pkg::CFG_B1: b1_r <= cfg_wdata;
        bqlpf_pkg::CFG_B2: b2_r <= cfg_wdata;
        bqlpf_pkg::CFG_A1: a1_r <= cfg_wdata;
        bqlpf_pkg::CFG_A2: a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand selection
  always_comb begin
    case (uc.coef_sel)
      bqlpf_pkg::CS_A1: coef_op = a1_r;
      bqlpf_pkg::CS_A2: coef_op = a2_r;
      bqlpf_pkg::CS_B0: coef_op = b0_r;
      bqlpf_pkg::CS_B1: coef_op = b1_r;
      bqlpf_pkg::CS_B2: coef_op = b2_r;
      default:          coef_op = '0;
    endcase
  end

  always_comb begin
    case (uc.st_sel)
      bqlpf_pkg::SS_D1: st_op = d1_r;
      bqlpf_pkg::SS_D2: st_op = d2_r;
      bqlpf_pkg::SS_W:  st_op = w_r;
      default:          st_op = '0;
    endcase
  end

  // rounding: add half an lsb, then floor shift
  assign acc_rnd = {acc_r[ACC_W-1], acc_r} + RND_HALF;
  assign acc_q   = acc_rnd >>> COEF_FRAC_BITS;

  // w = sat(x - round(a1*d1 + a2*d2))
  assign w_full = {{(ACC_W + 2 - SAMPLE_WIDTH){x_r[SAMPLE_WIDTH-1]}}, x_r}
                - {acc_q[ACC_W], acc_q};

  always_comb begin
    w_clip = 1'b1;
    if (w_full > W_MAX) begin
      w_nxt = W_MAX[STATE_WIDTH-1:0];
    end else if (w_full < W_MIN) begin
      w_nxt = W_MIN[STATE_WIDTH-1:0];
    end else begin
      w_nxt  = w_full[STATE_WIDTH-1:0];
      w_clip = 1'b0;
    end
  end

  // y = sat(round(b0*w + b1*d1 + b2*d2))
  always_comb begin
    y_clip = 1'b1;
    if (acc_q > Y_MAX) begin
      y_nxt = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (acc_q < Y_MIN) begin
      y_nxt = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_nxt  = acc_q[SAMPLE_WIDTH-1:0];
      y_clip = 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (uc.ld_x && adv) begin
      x_r <= in_sample_in;
    end
    if (uc.mul_en) begin
      prod_r <= coef_op * st_op;
    end
    case (uc.acc_op)
      bqlpf_pkg::ACC_LOAD: acc_r <= {{2{prod_r[PROD_W-1]}}, prod_r};
      bqlpf_pkg::ACC_ADD:  acc_r <= acc_r + {{2{prod_r[PROD_W-1]}}, prod_r};
      default: ;
    endcase
    if (uc.ld_w) begin
      w_r    <= w_nxt;
      clip_r <= w_clip;
    end
    if (uc.ld_y && adv) begin
      out_sample_r <= y_nxt;
      out_sat_r    <= clip_r | y_clip;
    end
  end

  // delay line and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r        <= '0;
      d2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (uc.ld_y && adv) begin
        d2_r        <= d1_r;
        d1_r        <= w_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

endmodule

>>> sv/bqlpf_chk.sv
// ----------------------------------------------------------------------------
// bqlpf_chk
// Port-level checks for the biquad low-pass filter, bound to the top level.
// ----------------------------------------------------------------------------
module bqlpf_chk #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_sample_out,
  input logic                    out_saturated
);

  // a result held back by the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out)
                               && $stable(out_saturated))
    else $error("stalled result changed or vanished");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // one sample in flight: after an input transfer the block is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in work");

  // no result can appear in the cycle after an input transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind biquad_lowpass_filter bqlpf_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqlpf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_saturated  (out_saturated)
);

>>> verif/biquad_check.sv
// ----------------------------------------------------------------------------
// biquad_check
// Watches the sample, result and coefficient ports of the biquad filter,
// predicts every filtered sample in fixed point, and compares results in
// order of arrival. Reports mismatch and outstanding-result counts.
// ----------------------------------------------------------------------------
module biquad_check #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int STATE_WIDTH    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_in,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    out_sample_out,
  input  logic                              out_saturated,
  input  logic                              cfg_wr_en,
  input  logic [bqlpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqlpf_pkg::COEF_W-1:0]      cfg_wdata,
  output int                                mismatches,
  output int                                in_flight
);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sat;
  } filtered_t;

  filtered_t filtered_q[$];
  filtered_t want;
  int        bad_seen = 0;

  logic signed [bqlpf_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [STATE_WIDTH-1:0]       dly1, dly2;

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round to nearest, ties towards +inf
  function automatic longint round_frac(input longint acc);
    return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  endfunction

  task automatic filter_step(input logic signed [SAMPLE_WIDTH-1:0] x);
    longint    fb, w_raw, w, y_raw, y;
    filtered_t r;
    fb    = round_frac(longint'(coef_a1) * longint'(dly1) +
                       longint'(coef_a2) * longint'(dly2));
    w_raw = longint'(x) - fb;
    w     = clamp_to(w_raw, STATE_WIDTH);
    y_raw = round_frac(longint'(coef_b0) * w +
                       longint'(coef_b1) * longint'(dly1) +
                       longint'(coef_b2) * longint'(dly2));
    y     = clamp_to(y_raw, SAMPLE_WIDTH);
    r.sample = y[SAMPLE_WIDTH-1:0];
    r.sat    = (w != w_raw) || (y != y_raw);
    filtered_q.push_back(r);
    dly2 = dly1;
    dly1 = w[STATE_WIDTH-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      coef_b0 = bqlpf_pkg::COEF_B0_RESET;
      coef_b1 = '0;
      coef_b2 = '0;
      coef_a1 = '0;
      coef_a2 = '0;
      dly1    = '0;
      dly2    = '0;
      filtered_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          bqlpf_pkg::CFG_B0: coef_b0 = cfg_wdata;
          bqlpf_pkg::CFG_B1: coef_b1 = cfg_wdata;
          bqlpf_pkg::CFG_B2: coef_b2 = cfg_wdata;
          bqlpf_pkg::CFG_A1: coef_a1 = cfg_wdata;
          bqlpf_pkg::CFG_A2: coef_a2 = cfg_wdata;
          default: ; // spare index, write dropped
        endcase
      end
      if (in_valid && !in_stall) filter_step(in_sample_in);
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          if (bad_seen < 10)
            $display("[%0t] unexpected result: sample %0d sat %0b", $realtime,
                     out_sample_out, out_saturated);
          bad_seen++;
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_out !== want.sample || out_saturated !== want.sat) begin
            if (bad_seen < 10)
              $display("[%0t] result mismatch: expected sample %0d sat %0b, got %0d sat %0b",
                       $realtime, want.sample, want.sat, out_sample_out, out_saturated);
            bad_seen++;
          end
        end
      end
    end
    // registered so the stimulus side reads a settled value at the edge
    in_flight  <= filtered_q.size();
    mismatches <= bad_seen;
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the biquad low-pass filter: directed extremes, runaway and
// flush cases, then random coefficient sets and samples with random idling
// on both channels. Checking is done by biquad_check.
// ----------------------------------------------------------------------------
module tb;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int STATE_WIDTH    = 32;
  localparam int Q_ONE          = 1 << COEF_FRAC_BITS;
  localparam int COEF_MAX       = (1 << (bqlpf_pkg::COEF_W - 1)) - 1;
  localparam int COEF_MIN       = -(1 << (bqlpf_pkg::COEF_W - 1));
  localparam int SAMPLE_MAX     = (1 << (SAMPLE_WIDTH - 1)) - 1;
  localparam int SAMPLE_MIN     = -(1 << (SAMPLE_WIDTH - 1));

  logic                            clk;
  logic                            rst_n        = 1'b0;
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic signed [SAMPLE_WIDTH-1:0]  in_sample_in = '0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0]  out_sample_out;
  logic                            out_saturated;
  logic                            cfg_wr_en    = 1'b0;
  logic [bqlpf_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [bqlpf_pkg::COEF_W-1:0]    cfg_wdata    = '0;

  int mismatches;
  int in_flight;
  int idle_pct   = 0;
  int stall_left = 0;

  biquad_lowpass_filter #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .STATE_WIDTH   (STATE_WIDTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_saturated (out_saturated),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  biquad_check #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .STATE_WIDTH   (STATE_WIDTH)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_saturated (out_saturated),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .in_flight     (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall bursts, started with chance idle_pct
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_sample(input int s);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s[SAMPLE_WIDTH-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [bqlpf_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[bqlpf_pkg::COEF_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_coefs(input int b0, input int b1, input int b2,
                            input int a1, input int a2, input bit spare);
    int spare_idx;
    reg_write(bqlpf_pkg::CFG_B0, b0);
    reg_write(bqlpf_pkg::CFG_B1, b1);
    reg_write(bqlpf_pkg::CFG_B2, b2);
    reg_write(bqlpf_pkg::CFG_A1, a1);
    reg_write(bqlpf_pkg::CFG_A2, a2);
    // indexes past the last register must be dropped
    if (spare) begin
      spare_idx = int'(bqlpf_pkg::CFG_A2) + 1 + $urandom_range(0, 2);
      reg_write(spare_idx[bqlpf_pkg::CFG_IDX_W-1:0], $urandom);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return $urandom_range(0, 2 * SAMPLE_MAX + 1) + SAMPLE_MIN;
    if (r < 15) return $urandom_range(0, 2000) - 1000;
    if (r < 17) return SAMPLE_MAX;
    if (r < 19) return SAMPLE_MIN;
    return 0;
  endfunction

  function automatic int corner_coef();
    case ($urandom_range(0, 2))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      default: return 0;
    endcase
  endfunction

  function automatic int half_coef();
    return $urandom_range(0, Q_ONE) - Q_ONE / 2;
  endfunction

  initial begin
    int p, k, n, kind, lim, a1, a2;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // unity pass-through straight out of reset
    push_sample(0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(1);
    push_sample(-1);
    push_sample(16'h5555);
    push_sample(-16'sh5556);
    drain();

    // gain of nearly 8: output clips both ways
    load_coefs(COEF_MAX, 0, 0, 0, 0, 1'b1);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(100);
    drain();

    // all corners, feedback runs away until the delay line clips
    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, 1'b0);
    for (k = 0; k < 10; k++) push_sample((k % 3 == 2) ? SAMPLE_MIN : SAMPLE_MAX);
    drain();

    // no feedback: two zero samples flush the delay line
    load_coefs(Q_ONE, -Q_ONE / 2, -Q_ONE / 2, 0, 0, 1'b1);
    push_sample(0);
    push_sample(0);
    push_sample(0);
    drain();

    for (p = 0; p < 10; p++) begin
      kind = (p == 9) ? 0 : p % 4;
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 50;
      endcase
      if (p == 9) idle_pct = 0;
      case (kind)
        0: begin
          // inside the stability triangle, with some margin
          a2  = $urandom_range(0, 111410) - 52428;
          lim = ((Q_ONE + a2) * 95) / 100;
          a1  = $urandom_range(0, 2 * lim) - lim;
          load_coefs(half_coef(), half_coef(), half_coef(), a1, a2, 1'b0);
        end
        1: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
        2: load_coefs(corner_coef(), corner_coef(), corner_coef(),
                      corner_coef(), corner_coef(), 1'b0);
        default: begin
          // weak feedback drags a clipped state back into range
          load_coefs($urandom, $urandom, $urandom,
                     $urandom_range(0, Q_ONE / 2) - Q_ONE / 4,
                     $urandom_range(0, Q_ONE / 2) - Q_ONE / 4, 1'b1);
        end
      endcase
      n = $urandom_range(105, 115);
      for (k = 0; k < n; k++) push_sample(pick_sample());
      drain();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bqlpf_pkg.sv
sv/biquad_lowpass_filter.sv
sv/bqlpf_chk.sv
verif/biquad_check.sv
verif/tb.sv
